// ===== design/assert_macros.svh =====
// Assertion macros used by multi_list_reverse_splice_manager.
// Expects signals named clk and arst_n in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at each rising clock edge, ignored while reset is asserted.
`define MLRSM_ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);

// Checked at each rising clock edge, reset included.
`define MLRSM_ASSERT_ANY(label, prop, msg) \
	label: assert property (@(posedge clk) prop) \
	else $error(msg);

`endif

// ===== design/mlrsm_pkg.sv =====
// Shared types and constants for the multi-list splice manager.
// No dependencies; imported by multi_list_reverse_splice_manager.
package mlrsm_pkg;

	// Sizing of the list table and the node pool.
	localparam int LIST_COUNT = 8;
	localparam int POOL_NODES = 1024;
	localparam int VALUE_BITS = 31;
	localparam int LIST_W     = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;
	localparam int IDX_W      = $clog2(POOL_NODES);
	localparam int FRESH_W    = IDX_W + 1;

	// Operation codes of the request field func.
	localparam logic [1:0] FUNC_ENTER   = 2'd0;
	localparam logic [1:0] FUNC_LEAVE   = 2'd1;
	localparam logic [1:0] FUNC_MIGRATE = 2'd2;

	// Status codes of the response.
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_EMPTY_POP = 2'd1;
	localparam logic [1:0] STATUS_FULL      = 2'd2;
	localparam logic [1:0] STATUS_EMPTY_MIG = 2'd3;

	// Request transaction payload.
	typedef struct packed {
		logic [1:0]            func;
		logic [2:0]            rail;
		logic [2:0]            target_rail;
		logic [VALUE_BITS-1:0] value;
	} req_t;

	// Response transaction payload.
	typedef struct packed {
		logic [1:0]            status;
		logic [VALUE_BITS-1:0] popped_value;
	} rsp_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_PUSH_FH,
		S_PUSH_LINK,
		S_PUSH_RMW,
		S_POP_RD,
		S_POP_RMW,
		S_MIG_D,
		S_MIG_TS,
		S_MIG_TD,
		S_RESP
	} state_t;

endpackage

// ===== design/multi_list_reverse_splice_manager.sv =====
// Top level of the multi-list splice manager: sequencer, node memories, list table.
// Depends on mlrsm_pkg and assert_macros.svh.
//
// Usage: requests arrive on req (req_valid/req_ready) and each one produces
// exactly one response transaction on rsp (rsp_valid/rsp_ready), in order.
// A request pushes a value at a list tail (enter), pops the tail (leave) or
// reverses one list onto the tail of another (migrate). Nodes are XOR linked
// and live in two single-port-read, single-port-write memories (value and
// link) with registered reads.
// Timing: one request is handled at a time, and a new request is taken only
// after the previous result is loaded into the response register. The error
// cases, unused code and same-list migrate go straight from decode to the
// response step; enter, leave and migrate first pass through the steps that
// read and rewrite the link memory, which has a single read port.
// Reset: arst_n clears all lists, the free chain and the allocator; there is
// no clearing pass. Node memories need no reset.
// Stall: the response register holds a result until taken; a request may be
// accepted meanwhile, and the sequencer waits in its final step if the
// register is still full when the next result is ready.
`include "assert_macros.svh"

module multi_list_reverse_splice_manager
	import mlrsm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	// Sequencer and working registers.
	state_t state_q, state_d;
	req_t   op_q;
	logic [IDX_W-1:0]   free_q, free_d;
	logic [FRESH_W-1:0] fresh_q, fresh_d;
	logic [IDX_W-1:0]   n_q, n_d;
	logic [IDX_W-1:0]   t_q, t_d;
	logic [IDX_W-1:0]   h_q, h_d;
	logic [IDX_W-1:0]   td_q, td_d;
	rsp_t res_q, res_d;
	rsp_t rsp_q;
	logic rsp_valid_q;

	// List table.
	logic [IDX_W-1:0] head_q [LIST_COUNT];
	logic [IDX_W-1:0] tail_q [LIST_COUNT];
	logic             head_we, tail_we;
	logic [LIST_W-1:0] ht_idx;
	logic [IDX_W-1:0] head_wd, tail_wd;
	logic [LIST_W-1:0] src_idx, dst_idx, sel_idx;
	logic [IDX_W-1:0] sel_head, sel_tail;

	// Node memories.
	logic [IDX_W-1:0]      link_mem [POOL_NODES];
	logic [VALUE_BITS-1:0] val_mem  [POOL_NODES];
	logic                  lre, lwe, vre, vwe;
	logic [IDX_W-1:0]      lraddr, lwaddr, vraddr, vwaddr;
	logic [IDX_W-1:0]      lwdata, link_rd_q;
	logic [VALUE_BITS-1:0] vwdata, val_rd_q;

	logic accept, rsp_load;

	// Terms checked by the assertions.
	logic fresh_ok, link_clash, rsp_stuck;

	// Handshake.
	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign rsp_load  = (state_q == S_RESP) && (!rsp_valid_q || rsp_ready);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// List selection: the source list, or the target list while it is fetched.
	assign src_idx  = op_q.rail[LIST_W-1:0];
	assign dst_idx  = op_q.target_rail[LIST_W-1:0];
	assign sel_idx  = (state_q == S_MIG_D) ? dst_idx : src_idx;
	assign sel_head = head_q[sel_idx];
	assign sel_tail = tail_q[sel_idx];

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_DECODE;
			end
			S_DECODE: begin
				case (op_q.func)
					FUNC_ENTER: begin
						if (free_q != '0) state_d = S_PUSH_FH;
						else if (fresh_q < FRESH_W'(POOL_NODES)) state_d = S_PUSH_LINK;
						else state_d = S_RESP;
					end
					FUNC_LEAVE: begin
						if (sel_head == '0 || sel_tail == '0) state_d = S_RESP;
						else state_d = S_POP_RD;
					end
					FUNC_MIGRATE: begin
						if (sel_head == '0 || sel_tail == '0 || src_idx == dst_idx) begin
							state_d = S_RESP;
						end else begin
							state_d = S_MIG_D;
						end
					end
					default: state_d = S_RESP;
				endcase
			end
			S_PUSH_FH:   state_d = S_PUSH_LINK;
			S_PUSH_LINK: state_d = (t_q != '0) ? S_PUSH_RMW : S_RESP;
			S_PUSH_RMW:  state_d = S_RESP;
			S_POP_RD:    state_d = (link_rd_q != '0) ? S_POP_RMW : S_RESP;
			S_POP_RMW:   state_d = S_RESP;
			S_MIG_D:     state_d = S_MIG_TS;
			S_MIG_TS:    state_d = (td_q != '0) ? S_MIG_TD : S_RESP;
			S_MIG_TD:    state_d = S_RESP;
			S_RESP: begin
				if (rsp_load) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Datapath control: memory accesses, list table writes and register updates.
	always_comb begin
		lre     = 1'b0;
		lraddr  = '0;
		lwe     = 1'b0;
		lwaddr  = '0;
		lwdata  = '0;
		vre     = 1'b0;
		vraddr  = '0;
		vwe     = 1'b0;
		vwaddr  = '0;
		vwdata  = '0;
		head_we = 1'b0;
		tail_we = 1'b0;
		ht_idx  = src_idx;
		head_wd = '0;
		tail_wd = '0;
		free_d  = free_q;
		fresh_d = fresh_q;
		n_d     = n_q;
		t_d     = t_q;
		h_d     = h_q;
		td_d    = td_q;
		res_d   = res_q;
		case (state_q)
			S_IDLE: begin
				res_d = '0;
			end
			S_DECODE: begin
				case (op_q.func)
					FUNC_ENTER: begin
						// Reuse a freed node first, then a fresh one.
						t_d = sel_tail;
						if (free_q != '0) begin
							n_d    = free_q;
							lre    = 1'b1;
							lraddr = free_q;
						end else if (fresh_q < FRESH_W'(POOL_NODES)) begin
							n_d     = fresh_q[IDX_W-1:0];
							fresh_d = FRESH_W'(fresh_q + 1'b1);
						end else begin
							res_d.status = STATUS_FULL;
						end
					end
					FUNC_LEAVE: begin
						t_d = sel_tail;
						if (sel_head == '0 || sel_tail == '0) begin
							res_d.status = STATUS_EMPTY_POP;
						end else begin
							lre    = 1'b1;
							lraddr = sel_tail;
							vre    = 1'b1;
							vraddr = sel_tail;
						end
					end
					FUNC_MIGRATE: begin
						h_d = sel_head;
						t_d = sel_tail;
						if (sel_head == '0 || sel_tail == '0) begin
							res_d.status = STATUS_EMPTY_MIG;
						end else if (src_idx == dst_idx) begin
							// Reversal in place is a swap of the end pointers.
							head_we = 1'b1;
							tail_we = 1'b1;
							head_wd = sel_tail;
							tail_wd = sel_head;
						end else begin
							// The source ends up empty; its ends are kept in h_q and t_q.
							head_we = 1'b1;
							tail_we = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			S_PUSH_FH: begin
				free_d = link_rd_q;
			end
			S_PUSH_LINK: begin
				vwe    = 1'b1;
				vwaddr = n_q;
				vwdata = op_q.value;
				lwe    = 1'b1;
				lwaddr = n_q;
				lwdata = t_q;
				if (t_q != '0) begin
					lre    = 1'b1;
					lraddr = t_q;
				end else begin
					head_we = 1'b1;
					tail_we = 1'b1;
					head_wd = n_q;
					tail_wd = n_q;
				end
			end
			S_PUSH_RMW: begin
				lwe     = 1'b1;
				lwaddr  = t_q;
				lwdata  = link_rd_q ^ n_q;
				tail_we = 1'b1;
				tail_wd = n_q;
			end
			S_POP_RD: begin
				// The old tail goes onto the free chain; n_q keeps its predecessor.
				res_d.popped_value = val_rd_q;
				n_d    = link_rd_q;
				lwe    = 1'b1;
				lwaddr = t_q;
				lwdata = free_q;
				free_d = t_q;
				if (link_rd_q != '0) begin
					lre     = 1'b1;
					lraddr  = link_rd_q;
					tail_we = 1'b1;
					tail_wd = link_rd_q;
				end else begin
					head_we = 1'b1;
					tail_we = 1'b1;
				end
			end
			S_POP_RMW: begin
				lwe    = 1'b1;
				lwaddr = n_q;
				lwdata = link_rd_q ^ t_q;
			end
			S_MIG_D: begin
				td_d   = sel_tail;
				lre    = 1'b1;
				lraddr = t_q;
			end
			S_MIG_TS: begin
				// The source tail becomes the node after the target tail.
				lwe    = 1'b1;
				lwaddr = t_q;
				lwdata = link_rd_q ^ td_q;
				ht_idx = dst_idx;
				if (td_q != '0) begin
					lre    = 1'b1;
					lraddr = td_q;
				end else begin
					head_we = 1'b1;
					tail_we = 1'b1;
					head_wd = t_q;
					tail_wd = h_q;
				end
			end
			S_MIG_TD: begin
				lwe     = 1'b1;
				lwaddr  = td_q;
				lwdata  = link_rd_q ^ t_q;
				ht_idx  = dst_idx;
				tail_we = 1'b1;
				tail_wd = h_q;
			end
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			free_q      <= '0;
			fresh_q     <= FRESH_W'(1);
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < LIST_COUNT; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			free_q  <= free_d;
			fresh_q <= fresh_d;
			if (head_we) head_q[ht_idx] <= head_wd;
			if (tail_we) tail_q[ht_idx] <= tail_wd;
			if (rsp_load) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

	// Payload and working registers.
	always_ff @(posedge clk) begin
		if (accept) op_q <= req;
		n_q   <= n_d;
		t_q   <= t_d;
		h_q   <= h_d;
		td_q  <= td_d;
		res_q <= res_d;
		if (rsp_load) rsp_q <= res_q;
	end

	// Link memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (lwe) link_mem[lwaddr] <= lwdata;
		if (lre) link_rd_q <= link_mem[lraddr];
	end

	// Value memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (vwe) val_mem[vwaddr] <= vwdata;
		if (vre) val_rd_q <= val_mem[vraddr];
	end

	// Assertions.
	assign fresh_ok   = (fresh_q != '0) && (fresh_q <= FRESH_W'(POOL_NODES));
	assign link_clash = lre && lwe && (lraddr == lwaddr);
	assign rsp_stuck  = (state_q == S_RESP) && rsp_valid_q && !rsp_ready;

	`MLRSM_ASSERT_CLK(a_fresh_range, fresh_ok, "fresh node counter out of range")
	`MLRSM_ASSERT_CLK(a_link_no_overlap, !link_clash, "link read and write hit the same node")
	`MLRSM_ASSERT_CLK(a_resp_wait, rsp_stuck |=> (state_q == S_RESP), "result left while held")
	`MLRSM_ASSERT_ANY(a_reset_quiet, !arst_n |=> !rsp_valid_q, "response valid during reset")

endmodule
